// ===== sv/mpct_pkg.sv =====
`default_nettype none

package mpct_pkg;

   localparam int POS_BITS_DEF = 12;

   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 12;
   localparam int CSR_IDX_W = 1;
   localparam int OUT_W   = 12;
   localparam int BTN_W   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_X = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Y = 1'd1;

   localparam logic [CFG_W-1:0] MAX_X_RST = 12'd1024;
   localparam logic [CFG_W-1:0] MAX_Y_RST = 12'd768;

   localparam int CURSOR_X_RST = 400;
   localparam int CURSOR_Y_RST = 300;

   // header bit positions
   localparam int HDR_SIGN_X = 4;
   localparam int HDR_SIGN_Y = 5;
   localparam int HDR_OVF_X  = 6;
   localparam int HDR_OVF_Y  = 7;

   typedef struct packed {
      logic [OUT_W-1:0] pos_x;
      logic [OUT_W-1:0] pos_y;
      logic [BTN_W-1:0] buttons;
      logic             dropped;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/mpct_core.sv =====
`default_nettype none

module mpct_core #(
   parameter int POS_BITS = mpct_pkg::POS_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [mpct_pkg::BYTE_W-1:0]   data_byte,
   input  wire logic [mpct_pkg::CFG_W-1:0]    max_x,
   input  wire logic [mpct_pkg::CFG_W-1:0]    max_y,
   output logic                               last,
   output mpct_pkg::result_type               result
);

   localparam int SUM_W = POS_BITS + 2;
   localparam int CMP_W = (POS_BITS + 1 > mpct_pkg::CFG_W) ? POS_BITS + 1 : mpct_pkg::CFG_W;
   localparam int DLT_W = mpct_pkg::BYTE_W + 1;

   localparam logic [1:0] IDX_HDR = 2'd0;
   localparam logic [1:0] IDX_DX  = 2'd1;
   localparam logic [1:0] IDX_DY  = 2'd2;

   logic [1:0]                  idx_ff, idx_in;
   logic [mpct_pkg::BYTE_W-1:0] hdr_ff, hdr_in;
   logic [mpct_pkg::BYTE_W-1:0] dx_ff, dx_in;
   logic [POS_BITS-1:0]         cx_ff, cx_in;
   logic [POS_BITS-1:0]         cy_ff, cy_in;

   logic signed [DLT_W-1:0] dx_s, dy_s;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic [CMP_W-1:0]        pos_mask, max_x_ext, max_y_ext, lim_x, lim_y;
   logic [CMP_W-1:0]        mag_x, mag_y, clp_x, clp_y;
   logic                    drop;

   assign last = (idx_ff == IDX_DY);
   assign drop = hdr_ff[mpct_pkg::HDR_OVF_X] | hdr_ff[mpct_pkg::HDR_OVF_Y];

   always_comb begin
      dx_s = $signed({hdr_ff[mpct_pkg::HDR_SIGN_X], dx_ff});
      dy_s = $signed({hdr_ff[mpct_pkg::HDR_SIGN_Y], data_byte});
      sum_x = $signed({2'b00, cx_ff}) + SUM_W'(dx_s);
      sum_y = $signed({2'b00, cy_ff}) - SUM_W'(dy_s);

      pos_mask  = CMP_W'({POS_BITS{1'b1}});
      max_x_ext = CMP_W'(max_x);
      max_y_ext = CMP_W'(max_y);
      lim_x = (max_x_ext > pos_mask) ? pos_mask : max_x_ext;
      lim_y = (max_y_ext > pos_mask) ? pos_mask : max_y_ext;

      mag_x = CMP_W'(sum_x[SUM_W-2:0]);
      mag_y = CMP_W'(sum_y[SUM_W-2:0]);
      if (sum_x[SUM_W-1]) begin
         clp_x = '0;
      end else if (mag_x > lim_x) begin
         clp_x = lim_x;
      end else begin
         clp_x = mag_x;
      end
      if (sum_y[SUM_W-1]) begin
         clp_y = '0;
      end else if (mag_y > lim_y) begin
         clp_y = lim_y;
      end else begin
         clp_y = mag_y;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      hdr_in = hdr_ff;
      dx_in  = dx_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      if (step) begin
         case (idx_ff)
            IDX_DX: begin
               dx_in  = data_byte;
               idx_in = IDX_DY;
            end
            IDX_DY: begin
               idx_in = IDX_HDR;
               if (!drop) begin
                  cx_in = POS_BITS'(clp_x);
                  cy_in = POS_BITS'(clp_y);
               end
            end
            default: begin
               hdr_in = data_byte;
               idx_in = IDX_DX;
            end
         endcase
      end
   end

   always_comb begin
      result.pos_x   = mpct_pkg::OUT_W'(cx_in);
      result.pos_y   = mpct_pkg::OUT_W'(cy_in);
      result.buttons = hdr_ff[mpct_pkg::BTN_W-1:0];
      result.dropped = drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IDX_HDR;
         hdr_ff <= '0;
         dx_ff  <= '0;
         cx_ff  <= POS_BITS'(mpct_pkg::CURSOR_X_RST);
         cy_ff  <= POS_BITS'(mpct_pkg::CURSOR_Y_RST);
      end else begin
         idx_ff <= idx_in;
         hdr_ff <= hdr_in;
         dx_ff  <= dx_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mouse_packet_cursor_tracker.sv =====
// Mouse packet decoder with clamped cursor.
// req channel: one controller byte per beat (req_data_byte, req_from_aux).
//   Bytes with req_from_aux low are taken and ignored.
// Every third mouse byte completes a packet and yields one rsp beat with
//   the cursor position, the header buttons and a dropped flag (overflow).
// csr port: index 0 writes max_x, index 1 writes max_y; write only when idle.
// The beat carrying a packet's last byte reaches rsp through the input
//   register, then the result register.
// Throughput: one req beat per cycle while req_stall is low; the cursor
//   update is a single add and clamp between the input and result registers.
// While rsp_stall holds a result, req beats keep flowing until the next
//   packet's last byte sits in the input register; req then stalls until
//   rsp drains.
// Reset: cursor 400/300, max 1024/768, packet assembly back at the header.
`default_nettype none

module mouse_packet_cursor_tracker #(
   parameter int POS_BITS = mpct_pkg::POS_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [mpct_pkg::BYTE_W-1:0]     req_data_byte,
   input  wire logic                            req_from_aux,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [mpct_pkg::OUT_W-1:0]           rsp_pos_x,
   output logic [mpct_pkg::OUT_W-1:0]           rsp_pos_y,
   output logic [mpct_pkg::BTN_W-1:0]           rsp_buttons,
   output logic                                 rsp_dropped,
   input  wire logic                            csr_wr_en,
   input  wire logic [mpct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mpct_pkg::CFG_W-1:0]      csr_data
);

   logic                        in_vld_ff, in_vld_in;
   logic [mpct_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        out_vld_ff, out_vld_in;
   mpct_pkg::result_type        out_ff, core_res;
   logic [mpct_pkg::CFG_W-1:0]  max_x_ff, max_y_ff;
   logic                        last, advance, step, req_take;

   assign advance   = in_vld_ff & (!last | !out_vld_ff | !rsp_stall);
   assign step      = advance;
   assign req_stall = in_vld_ff & !advance;
   assign req_take  = req_valid & !req_stall;

   always_comb begin
      if (req_take) begin
         in_vld_in = req_from_aux;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      out_vld_in = (step & last) | (out_vld_ff & rsp_stall);
   end

   mpct_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .max_x     (max_x_ff),
      .max_y     (max_y_ff),
      .last      (last),
      .result    (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         max_x_ff   <= mpct_pkg::MAX_X_RST;
         max_y_ff   <= mpct_pkg::MAX_Y_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en && csr_index == mpct_pkg::REG_MAX_X) begin
            max_x_ff <= csr_data;
         end
         if (csr_wr_en && csr_index == mpct_pkg::REG_MAX_Y) begin
            max_y_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (step && last) begin
         out_ff <= core_res;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_pos_x   = out_ff.pos_x;
   assign rsp_pos_y   = out_ff.pos_y;
   assign rsp_buttons = out_ff.buttons;
   assign rsp_dropped = out_ff.dropped;

endmodule

`default_nettype wire

// ===== tb/sv/mpct_cursor_checker.sv =====
`timescale 1ns / 1ps

module mpct_cursor_checker
   import mpct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   input  wire logic                  req_from_aux,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [OUT_W-1:0]      rsp_pos_x,
   input  wire logic [OUT_W-1:0]      rsp_pos_y,
   input  wire logic [BTN_W-1:0]      rsp_buttons,
   input  wire logic                  rsp_dropped,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_data,
   output int                         errors,
   output int                         pending,
   output int                         n_results,
   output int                         n_dropped
);

   localparam int POS_MAX = (1 << POS_BITS_DEF) - 1;

   localparam logic [1:0] SLOT_HDR = 2'd0;
   localparam logic [1:0] SLOT_DX  = 2'd1;
   localparam logic [1:0] SLOT_DY  = 2'd2;

   logic [CFG_W-1:0]        lim_x_reg;
   logic [CFG_W-1:0]        lim_y_reg;
   logic [1:0]              frame_pos;
   logic [BYTE_W-1:0]       hdr_byte;
   logic [BYTE_W-1:0]       dx_byte;
   logic [POS_BITS_DEF-1:0] cur_x;
   logic [POS_BITS_DEF-1:0] cur_y;
   result_type              expected_q[$];

   function automatic int eff_limit(logic [CFG_W-1:0] r);
      return (int'(r) > POS_MAX) ? POS_MAX : int'(r);
   endfunction

   function automatic int clamp_to(int v, int lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
   endfunction

   // completes the packet on its dy byte and moves the cursor unless the packet is dropped
   function automatic result_type finish_packet(logic [BYTE_W-1:0] dy_b);
      result_type r;
      int dx;
      int dy;
      r.dropped = hdr_byte[HDR_OVF_X] | hdr_byte[HDR_OVF_Y];
      if (!r.dropped) begin
         dx = int'(dx_byte) - (hdr_byte[HDR_SIGN_X] ? 256 : 0);
         dy = int'(dy_b) - (hdr_byte[HDR_SIGN_Y] ? 256 : 0);
         cur_x = POS_BITS_DEF'(clamp_to(int'(cur_x) + dx, eff_limit(lim_x_reg)));
         cur_y = POS_BITS_DEF'(clamp_to(int'(cur_y) - dy, eff_limit(lim_y_reg)));
      end
      r.pos_x   = OUT_W'(cur_x);
      r.pos_y   = OUT_W'(cur_y);
      r.buttons = hdr_byte[BTN_W-1:0];
      return r;
   endfunction

   task automatic report_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         lim_x_reg = MAX_X_RST;
         lim_y_reg = MAX_Y_RST;
         frame_pos = SLOT_HDR;
         hdr_byte  = '0;
         dx_byte   = '0;
         cur_x     = POS_BITS_DEF'(CURSOR_X_RST);
         cur_y     = POS_BITS_DEF'(CURSOR_Y_RST);
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_MAX_X: lim_x_reg = csr_data;
               REG_MAX_Y: lim_y_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall && req_from_aux) begin
            case (frame_pos)
               SLOT_DX: begin
                  dx_byte   = req_data_byte;
                  frame_pos = SLOT_DY;
               end
               SLOT_DY: begin
                  frame_pos = SLOT_HDR;
                  expected_q.push_back(finish_packet(req_data_byte));
               end
               default: begin
                  hdr_byte  = req_data_byte;
                  frame_pos = SLOT_DX;
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected rsp beat: expected none, got x=%0d y=%0d btn=%0d drop=%0d",
                        $time, rsp_pos_x, rsp_pos_y, rsp_buttons, rsp_dropped);
               errors++;
            end else begin
               want = expected_q.pop_front();
               report_field("pos_x", 16'(want.pos_x), 16'(rsp_pos_x));
               report_field("pos_y", 16'(want.pos_y), 16'(rsp_pos_y));
               report_field("buttons", 16'(want.buttons), 16'(rsp_buttons));
               report_field("dropped", 16'(want.dropped), 16'(rsp_dropped));
               n_results++;
               if (want.dropped) n_dropped++;
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// ===== tb/sv/tb_mouse_packet_cursor_tracker.sv =====
`timescale 1ns / 1ps

module tb_mouse_packet_cursor_tracker;
   import mpct_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_data_byte;
   logic                 req_from_aux;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [OUT_W-1:0]     rsp_pos_x;
   logic [OUT_W-1:0]     rsp_pos_y;
   logic [BTN_W-1:0]     rsp_buttons;
   logic                 rsp_dropped;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   int  errors;
   int  pending;
   int  n_results;
   int  n_dropped;
   int  n_aux;
   int  n_ignored;
   int  n_settings;
   int  cycles;
   int  hold_left;
   bit  calm;

   mouse_packet_cursor_tracker dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_from_aux  (req_from_aux),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_buttons   (rsp_buttons),
      .rsp_dropped   (rsp_dropped),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   mpct_cursor_checker u_cursor_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_from_aux  (req_from_aux),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_buttons   (rsp_buttons),
      .rsp_dropped   (rsp_dropped),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .errors        (errors),
      .pending       (pending),
      .n_results     (n_results),
      .n_dropped     (n_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: stalls rsp at random after each beat and at other times; calm stops new stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         hold_left = calm ? 0 : $urandom_range(0, 5);
         rsp_stall <= (hold_left != 0);
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= (hold_left != 0);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 5);
         rsp_stall <= 1'b1;
      end
   end

   // called right after a rising edge; returns at the edge that takes the beat
   task automatic send_beat(logic [BYTE_W-1:0] b, logic aux);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_from_aux  <= aux;
      do @(posedge clock); while (req_stall);
      if (aux) n_aux++;
      else n_ignored++;
   endtask

   task automatic send_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy);
      send_beat(hdr, 1'b1);
      send_beat(dx, 1'b1);
      send_beat(dy, 1'b1);
   endtask

   task automatic send_noisy(logic [7:0] b);
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0);
      send_beat(b, 1'b1);
   endtask

   task automatic run_random(int n_beats);
      int sent;
      logic [7:0] hdr;
      sent = 0;
      while (sent < n_beats) begin
         if ($urandom_range(0, 99) < 3) begin
            // stray mouse byte shifts the framing
            send_beat(8'($urandom), 1'b1);
            sent++;
         end else begin
            hdr = 8'($urandom);
            if ($urandom_range(0, 99) < 85) hdr[HDR_OVF_Y:HDR_OVF_X] = 2'b00;
            send_noisy(hdr);
            send_noisy(8'($urandom));
            send_noisy(8'($urandom));
            sent += 3;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(logic [CFG_W-1:0] lx, logic [CFG_W-1:0] ly);
      csr_wr_en <= 1'b1;
      csr_index <= REG_MAX_X;
      csr_data  <= lx;
      @(posedge clock);
      csr_index <= REG_MAX_Y;
      csr_data  <= ly;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_from_aux  = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = REG_MAX_X;
      csr_data      = '0;
      calm          = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored byte, delta extremes, sign bits, overflow, clamps
      send_beat(8'hFF, 1'b0);
      send_packet(8'h00, 8'hFF, 8'h00);
      send_packet(8'h17, 8'h00, 8'hFF);
      send_beat(8'h20, 1'b1);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h55, 1'b0);
      send_beat(8'h00, 1'b1);
      send_packet(8'h45, 8'h12, 8'h34);
      send_packet(8'hC2, 8'hAB, 8'hCD);
      send_packet(8'h00, 8'hFF, 8'hFF);
      send_packet(8'h00, 8'hFF, 8'hFF);
      run_random(170);
      drain();

      set_limits(12'd4095, 12'd4095);
      calm = 1'b1;
      run_random(170);
      repeat (4) send_packet(8'h20, 8'hFF, 8'h01);
      drain();

      // lowered below the cursor
      set_limits(12'd100, 12'd50);
      calm = 1'b0;
      run_random(170);
      drain();

      set_limits(12'd0, 12'd0);
      run_random(120);
      drain();

      set_limits(12'd4095, 12'd0);
      run_random(170);
      drain();

      set_limits(12'($urandom), 12'($urandom));
      calm = 1'b1;
      run_random(80);
      calm = 1'b0;
      run_random(90);
      drain();

      $display("sent %0d mouse beats and %0d ignored bytes over %0d limit settings",
               n_aux, n_ignored, n_settings + 1);
      $display("checked %0d packet results, %0d dropped for overflow", n_results, n_dropped);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mpct_pkg.sv
sv/mpct_core.sv
sv/mouse_packet_cursor_tracker.sv
tb/sv/mpct_cursor_checker.sv
tb/sv/tb_mouse_packet_cursor_tracker.sv
